@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types for the WebSocket frame deframer
// Parser phases, result record and status passed to the top level.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int RSV_W   = 3;
    localparam int OP_W    = 4;
    localparam int KEY_N   = 4;
    localparam int KEY_IW  = $clog2(KEY_N);
    localparam int KCNT_W  = KEY_IW + 1;
    localparam int TDATA_W = 24;

    typedef enum logic [1:0] {
        PH_HDR1 = 2'd0,
        PH_HDR2 = 2'd1,
        PH_KEY  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              has_byte;
        logic [LEN_W-1:0]  payload_index;
        logic              final_fragment;
        logic [RSV_W-1:0]  reserved_bits;
        logic [OP_W-1:0]   frame_opcode;
        logic              was_masked;
        logic              last;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   emit;
    } status_t;

endpackage

@@ hw/rtl/wsd_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser: frame header and payload parser
// Holds the frame state, unmasks payload bytes and forms one result per payload beat or empty frame.
// ----------------------------------------------------------------------------
module wsd_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [7:0]               data_byte,
    output wsd_pkg::result_t         result,
    output wsd_pkg::status_t         status
);
    import wsd_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic               fin_reg,    fin_next;
    logic [RSV_W-1:0]   rsv_reg,    rsv_next;
    logic [OP_W-1:0]    op_reg,     op_next;
    logic               mask_reg,   mask_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [BYTE_W-1:0]  key_reg     [KEY_N];
    logic [BYTE_W-1:0]  key_next    [KEY_N];
    logic [KCNT_W-1:0]  kcnt_reg,   kcnt_next;
    logic [LEN_W-1:0]   bcnt_reg,   bcnt_next;
    logic               emit;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_has;
    logic               out_last;
    logic [LEN_W:0]     idx_inc;

    always_comb
    begin
        phase_next = phase_reg;
        fin_next   = fin_reg;
        rsv_next   = rsv_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        kcnt_next  = kcnt_reg;
        bcnt_next  = bcnt_reg;
        for (int i = 0; i < KEY_N; i++)
        begin
            key_next[i] = key_reg[i];
        end
        emit     = 1'b0;
        out_byte = '0;
        out_has  = 1'b0;
        out_last = 1'b0;
        idx_inc  = {1'b0, bcnt_reg} + {{LEN_W{1'b0}}, 1'b1};

        unique case (phase_reg)
            PH_HDR1:
            begin
                fin_next   = data_byte[7];
                rsv_next   = data_byte[6:4];
                op_next    = data_byte[3:0];
                kcnt_next  = '0;
                bcnt_next  = '0;
                phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                mask_next = data_byte[7];
                len_next  = data_byte[LEN_W-1:0];
                if (data_byte[7])
                begin
                    phase_next = PH_KEY;
                end
                else if (data_byte[LEN_W-1:0] == '0)
                begin
                    emit       = 1'b1;
                    out_last   = 1'b1;
                    phase_next = PH_HDR1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_KEY:
            begin
                key_next[kcnt_reg[KEY_IW-1:0]] = data_byte;
                kcnt_next = kcnt_reg + {{(KCNT_W-1){1'b0}}, 1'b1};
                if (kcnt_next[KCNT_W-1])
                begin
                    if (len_reg == '0)
                    begin
                        emit       = 1'b1;
                        out_last   = 1'b1;
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                emit     = 1'b1;
                out_has  = 1'b1;
                out_byte = mask_reg ? (data_byte ^ key_reg[bcnt_reg[KEY_IW-1:0]])
                                    : data_byte;
                out_last = (idx_inc >= {1'b0, len_reg});
                bcnt_next = idx_inc[LEN_W-1:0];
                if (out_last)
                begin
                    phase_next = PH_HDR1;
                end
            end
            default:
            begin
                phase_next = PH_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            fin_reg   <= 1'b0;
            rsv_reg   <= '0;
            op_reg    <= '0;
            mask_reg  <= 1'b0;
            len_reg   <= '0;
            kcnt_reg  <= '0;
            bcnt_reg  <= '0;
            for (int i = 0; i < KEY_N; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            rsv_reg   <= rsv_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            kcnt_reg  <= kcnt_next;
            bcnt_reg  <= bcnt_next;
            for (int i = 0; i < KEY_N; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    assign result.payload_byte   = out_byte;
    assign result.has_byte       = out_has;
    assign result.payload_index  = out_has ? bcnt_reg : '0;
    assign result.final_fragment = fin_next;
    assign result.reserved_bits  = rsv_next;
    assign result.frame_opcode   = op_next;
    assign result.was_masked     = mask_next;
    assign result.last           = out_last;

    assign status.phase = phase_reg;
    assign status.emit  = emit;

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket frame parser, short lengths only
//
//   port group   dir   tdata bits                                    extra
//   s_*          in    [7:0] data_byte                               -
//   m_*          out   [7:0] payload_byte, [14:8] payload_index,     tuser has_byte
//                      [15] final_fragment, [18:16] reserved_bits,   tlast last
//                      [22:19] frame_opcode, [23] was_masked
//
// One input beat per cycle while s_tready is high; a result is registered and appears in the cycle after its beat.
// The output register sets the rate: a new beat is taken whenever the
// register is empty or being drained in the same cycle.
// Header and key beats produce no payload output; an empty frame gives one marker on its last header or key beat.
// Reset returns the parser to expect a first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [14:8] payload_index,
                                   // [15] final_fragment, [18:16] reserved_bits,
                                   // [22:19] frame_opcode, [23] was_masked
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast
);
    import wsd_pkg::*;

    result_t res;
    status_t stat;
    logic    accept;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .data_byte (s_tdata),
        .result    (res),
        .status    (stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = stat.emit;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && stat.emit)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.was_masked, out_reg.frame_opcode, out_reg.reserved_bits,
                       out_reg.final_fragment, out_reg.payload_index,
                       out_reg.payload_byte};
    assign m_tuser  = out_reg.has_byte;
    assign m_tlast  = out_reg.last;

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[14:0] == 15'd0))
        else $error("empty-frame marker malformed");

    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.emit && res.last) |=> (stat.phase == PH_HDR1))
        else $error("parser did not return to header after last beat");

    a_data_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stat.emit && res.has_byte) |-> (stat.phase == PH_DATA))
        else $error("payload byte emitted outside payload phase");

endmodule

@@ test/wsd_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_frame_checker: result predictor and scoreboard for the frame deframer
// Watches both stream ports. Every accepted input byte runs through a local
// copy of the frame parser. Any payload byte or empty-frame marker it yields
// is queued. Every result beat is compared field by field against the
// oldest queued entry. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module wsd_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] payload_byte, [14:8] payload_index,
                                   // [15] final_fragment, [18:16] reserved_bits,
                                   // [22:19] frame_opcode, [23] was_masked
    input  logic        m_tuser,   // [0] has_byte
    input  logic        m_tlast,
    output int          pending,
    output int          fail_count
);
    import wsd_pkg::*;

    phase_t             frame_phase;
    logic               hdr_fin;
    logic [RSV_W-1:0]   hdr_rsv;
    logic [OP_W-1:0]    hdr_op;
    logic               hdr_masked;
    logic [LEN_W-1:0]   hdr_len;
    logic [BYTE_W-1:0]  mask_key [KEY_N];
    logic [KCNT_W-1:0]  key_seen;
    logic [LEN_W-1:0]   pay_pos;
    result_t            payload_q [$];
    result_t            want;

    function automatic result_t frame_result(input logic [BYTE_W-1:0] value,
                                             input logic has, input logic [LEN_W-1:0] idx,
                                             input logic is_last);
        result_t r;
        r.payload_byte   = value;
        r.has_byte       = has;
        r.payload_index  = idx;
        r.final_fragment = hdr_fin;
        r.reserved_bits  = hdr_rsv;
        r.frame_opcode   = hdr_op;
        r.was_masked     = hdr_masked;
        r.last           = is_last;
        return r;
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W:0]    next_pos;
        logic [BYTE_W-1:0] plain;
        logic              is_last;
        case (frame_phase)
            PH_HDR1:
            begin
                hdr_fin     = b[7];
                hdr_rsv     = b[6:4];
                hdr_op      = b[3:0];
                key_seen    = '0;
                pay_pos     = '0;
                frame_phase = PH_HDR2;
            end
            PH_HDR2:
            begin
                hdr_masked = b[7];
                hdr_len    = b[LEN_W-1:0];
                if (hdr_masked)
                    frame_phase = PH_KEY;
                else if (hdr_len == '0)
                begin
                    payload_q.push_back(frame_result('0, 1'b0, '0, 1'b1));
                    frame_phase = PH_HDR1;
                end
                else
                    frame_phase = PH_DATA;
            end
            PH_KEY:
            begin
                mask_key[key_seen[KEY_IW-1:0]] = b;
                key_seen = key_seen + 1'b1;
                if (key_seen >= KEY_N)
                begin
                    if (hdr_len == '0)
                    begin
                        payload_q.push_back(frame_result('0, 1'b0, '0, 1'b1));
                        frame_phase = PH_HDR1;
                    end
                    else
                        frame_phase = PH_DATA;
                end
            end
            default:
            begin
                plain    = hdr_masked ? (b ^ mask_key[pay_pos[KEY_IW-1:0]]) : b;
                next_pos = {1'b0, pay_pos} + 1'b1;
                is_last  = (next_pos >= {1'b0, hdr_len});
                payload_q.push_back(frame_result(plain, 1'b1, pay_pos, is_last));
                pay_pos  = next_pos[LEN_W-1:0];
                if (is_last)
                    frame_phase = PH_HDR1;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase = PH_HDR1;
            hdr_fin     = 1'b0;
            hdr_rsv     = '0;
            hdr_op      = '0;
            hdr_masked  = 1'b0;
            hdr_len     = '0;
            for (int i = 0; i < KEY_N; i++)
                mask_key[i] = '0;
            key_seen    = '0;
            pay_pos     = '0;
            payload_q.delete();
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            // results trail their input byte through the output register: check first
            if (m_tvalid && m_tready)
            begin
                if (payload_q.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata 0x%0h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = payload_q.pop_front();
                    check_field("payload_byte", int'(want.payload_byte),
                                int'(m_tdata[7:0]));
                    check_field("has_byte", int'(want.has_byte), int'(m_tuser));
                    check_field("payload_index", int'(want.payload_index),
                                int'(m_tdata[14:8]));
                    check_field("final_fragment", int'(want.final_fragment),
                                int'(m_tdata[15]));
                    check_field("reserved_bits", int'(want.reserved_bits),
                                int'(m_tdata[18:16]));
                    check_field("frame_opcode", int'(want.frame_opcode),
                                int'(m_tdata[22:19]));
                    check_field("was_masked", int'(want.was_masked), int'(m_tdata[23]));
                    check_field("last", int'(want.last), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            pending <= payload_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the WebSocket frame deframer
// Drives a directed set of frames, then random frames mixed with stray bytes
// under three idle patterns, including one long receiver hold-off. The
// checker instance predicts and compares. This module only drives the block
// and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
    import wsd_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tready  = 1'b0;
    logic        long_hold = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          pending;
    int          fail_count;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          bytes_sent = 0;

    logic [7:0]  directed_bytes [22] = '{
        8'h81, 8'h00,
        8'h82, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44,
        8'hFF, 8'h01, 8'hFF,
        8'h00, 8'h85, 8'hA5, 8'h5A, 8'hFF, 8'h00,
        8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h7E
    };
    logic [3:0]  usual_ops [6] = '{4'h0, 4'h1, 4'h2, 4'h8, 4'h9, 4'hA};

    websocket_frame_deframer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    wsd_frame_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= !long_hold && ($urandom_range(99) >= recv_idle);

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len);
        logic       masked;
        logic [2:0] rsv;
        logic [3:0] op;
        masked = 1'($urandom_range(1));
        rsv    = ($urandom_range(99) < 70) ? 3'd0 : 3'($urandom_range(7));
        op     = ($urandom_range(99) < 80) ? usual_ops[$urandom_range(5)]
                                           : 4'($urandom_range(15));
        send_byte({1'($urandom_range(1)), rsv, op});
        send_byte({masked, LEN_W'(len)});
        if (masked)
            for (int i = 0; i < KEY_N; i++)
                send_byte(8'($urandom_range(255)));
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic random_traffic(input int budget, input int long_len);
        int start;
        int r;
        start = bytes_sent;
        if (long_len >= 0)
            send_frame(long_len);
        while (bytes_sent - start < budget)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_byte(8'($urandom_range(255)));
            else if (r < 60)
                send_frame($urandom_range(6));
            else if (r < 90)
                send_frame($urandom_range(24, 7));
            else
                send_frame($urandom_range(127, 25));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 14;
        recv_idle = 50;
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        random_traffic(230, 126);

        send_idle = 50;
        recv_idle = 14;
        random_traffic(230, 127);

        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                long_hold <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        random_traffic(230, -1);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
